[hw/rtl/mbe_pkg.sv]
// Shared types and constants for the escape-time block.
package mbe_pkg;

  localparam int IN_W      = 31;
  localparam int FRAC_BITS = 28;
  localparam int MAX_ITER  = 100;
  localparam int CNT_W     = 7;
  localparam int BAND_W    = 4;

  localparam int SUM_W = IN_W + 1;
  localparam int PRE_W = 2 * SUM_W;
  localparam int PIM_W = 2 * IN_W;
  localparam int NW    = PRE_W - FRAC_BITS + 1;

  localparam logic signed [NW-1:0] TWO = NW'(64'sd1 <<< (FRAC_BITS + 1));

  localparam int BAND_MUL = 205;
  localparam int BAND_SH  = 11;
  localparam int BAND_PW  = CNT_W + 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_mul;
    logic do_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic stop;
  } sts_t;

  function automatic logic [BAND_W-1:0] band_of(input logic [CNT_W-1:0] c);
    logic [BAND_PW-1:0] p;
    p = BAND_PW'(c) * BAND_PW'(BAND_MUL);
    return BAND_W'(p >> BAND_SH);
  endfunction

endpackage

[hw/rtl/mbe_ctrl.sv]
// Controller state machine: sequences load, multiply, update and result transfer.
module mbe_ctrl
  import mbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_MUL;
      S_MUL:  state_next = S_UPD;
      S_UPD:  state_next = sts.stop ? S_WAIT : S_MUL;
      S_WAIT: if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_MUL:  cmd.do_mul = 1'b1;
      S_UPD:  cmd.do_step = 1'b1;
      S_WAIT: cmd.load_out = slot_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_MUL))
    else $error("transfer in did not start a multiply");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwrote a pending transfer");

  a_rose_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_WAIT))
    else $error("result raised outside the wait state");

  a_mul_upd: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> (state == S_UPD))
    else $error("multiply not followed by update");

endmodule

[hw/rtl/mbe_dp.sv]
// Datapath: z registers, registered products, escape and repeat tests, result registers.
module mbe_dp
  import mbe_pkg::*;
(
  input  logic                     clk,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic signed [IN_W-1:0]   point_real,
  input  logic signed [IN_W-1:0]   point_imag,
  output logic        [CNT_W-1:0]  escape_count,
  output logic        [BAND_W-1:0] color_band,
  output logic                     band_drawn,
  output logic                     fixed_point_hit
);

  logic signed [IN_W-1:0]  zr, zi, cr, ci;
  logic signed [SUM_W-1:0] s_add, s_sub;
  logic signed [PRE_W-1:0] p_re;
  logic signed [PIM_W-1:0] p_im;
  logic signed [NW-1:0]    nr, ni;
  logic [CNT_W-1:0]        cnt;
  logic                    fixed_r;
  logic                    esc, rep, last;
  logic [BAND_W-1:0]       band;

  assign s_add = SUM_W'(zr) + SUM_W'(zi);
  assign s_sub = SUM_W'(zr) - SUM_W'(zi);

  // (zr+zi)(zr-zi) = zr^2 - zi^2; floor by arithmetic shift
  assign nr = NW'(p_re >>> FRAC_BITS) + NW'(cr);
  assign ni = NW'(p_im >>> (FRAC_BITS - 1)) + NW'(ci);

  assign esc  = (nr >= TWO) || (nr <= -TWO) || (ni >= TWO) || (ni <= -TWO);
  assign rep  = (nr == NW'(zr)) && (ni == NW'(zi));
  assign last = (cnt == CNT_W'(MAX_ITER - 1));

  assign sts.stop = esc || rep || last;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      zr      <= point_real;
      zi      <= point_imag;
      cr      <= point_real;
      ci      <= point_imag;
      cnt     <= CNT_W'(2);
      fixed_r <= 1'b0;
    end
    if (cmd.do_mul) begin
      p_re <= s_add * s_sub;
      p_im <= zr * zi;
    end
    if (cmd.do_step) begin
      if (esc) begin
        fixed_r <= 1'b0;
      end else if (rep) begin
        cnt     <= CNT_W'(MAX_ITER);
        fixed_r <= 1'b1;
      end else if (last) begin
        cnt     <= CNT_W'(MAX_ITER);
        fixed_r <= 1'b0;
      end else begin
        zr  <= IN_W'(nr);
        zi  <= IN_W'(ni);
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  assign band = band_of(cnt);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      escape_count    <= cnt;
      color_band      <= band;
      band_drawn      <= band inside {[BAND_W'(1):BAND_W'(9)]};
      fixed_point_hit <= fixed_r;
    end
  end

endmodule

[hw/rtl/mandelbrot_escape_time.sv]
// Top level of the fixed-point escape-time counter.
//
// Input channel (in_valid/in_ready) carries one point c as point_real and
// point_imag, signed with 28 fraction bits. Output channel (out_valid/
// out_ready) carries escape_count, color_band, band_drawn, fixed_point_hit.
// One result per input transfer, in order.
// Each iteration registers the products (zr+zi)(zr-zi) and zr*zi in the
// multiply state; the update and escape/repeat tests run in the update
// state that follows it. A point that stops moves to the wait state, which
// loads the result register and raises out_valid when the slot is free.
// in_ready is high only between points, in the idle state after the result
// is loaded; no new point is taken while one is in progress.
// A loaded result waits in the output register while the next point runs;
// if the receiver still stalls when that point finishes, the block holds
// it and takes no input until the register is free.
// Reset (rst, synchronous) drops any point in progress and clears
// out_valid.
module mandelbrot_escape_time
  import mbe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [IN_W-1:0]   point_real,
  input  logic signed [IN_W-1:0]   point_imag,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic        [CNT_W-1:0]  escape_count,
  output logic        [BAND_W-1:0] color_band,
  output logic                     band_drawn,
  output logic                     fixed_point_hit
);

  cmd_t cmd;
  sts_t sts;

  mbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mbe_dp u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .sts             (sts),
    .point_real      (point_real),
    .point_imag      (point_imag),
    .escape_count    (escape_count),
    .color_band      (color_band),
    .band_drawn      (band_drawn),
    .fixed_point_hit (fixed_point_hit)
  );

endmodule
